### hw/rtl/ktd_pkg.sv
// Shared types, key codes and decode helpers for the terminal key escape decoder.
// Used by every module of the block but ktd_ram; depends on nothing else.
`default_nettype none

package ktd_pkg;

   // One input item: a byte, or an end-of-input flush.
   typedef struct packed {
      logic       func;
      logic [7:0] in_byte;
   } req_type;

   // One result item: a key or mouse event.
   typedef struct packed {
      logic        event_kind;
      logic [4:0]  key_code;
      logic [20:0] code_point;
      logic [1:0]  mouse_button;
      logic [15:0] mouse_col;
      logic [15:0] mouse_row;
      logic        last_event;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic store;
      logic init;
      logic step;
      logic resolve;
      logic drop;
      logic push;
      logic hold;
      logic ld_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_eof;
      logic cnt_zero;
      logic at_end;
      logic step_done;
   } sts_type;

   localparam logic       FUNC_BYTE  = 1'b0;
   localparam logic       FUNC_FLUSH = 1'b1;

   localparam logic [4:0] KC_ESC   = 5'd0;
   localparam logic [4:0] KC_UP    = 5'd1;
   localparam logic [4:0] KC_DOWN  = 5'd2;
   localparam logic [4:0] KC_RIGHT = 5'd3;
   localparam logic [4:0] KC_LEFT  = 5'd4;
   localparam logic [4:0] KC_HOME  = 5'd5;
   localparam logic [4:0] KC_END   = 5'd6;
   localparam logic [4:0] KC_F1    = 5'd7;
   localparam logic [4:0] KC_INS   = 5'd19;
   localparam logic [4:0] KC_DEL   = 5'd20;
   localparam logic [4:0] KC_PGUP  = 5'd21;
   localparam logic [4:0] KC_PGDN  = 5'd22;
   localparam logic [4:0] KC_ENTER = 5'd23;
   localparam logic [4:0] KC_TAB   = 5'd24;
   localparam logic [4:0] KC_BKSP  = 5'd25;
   localparam logic [4:0] KC_CTRL  = 5'd26;
   localparam logic [4:0] KC_CHAR  = 5'd27;

   localparam logic [7:0]  CH_ESC     = 8'h1B;
   localparam logic [20:0] CP_BAD     = 21'h00FFFD;
   localparam logic [20:0] CP_MAX     = 21'h10FFFF;
   localparam logic [15:0] DEC_MAX    = 16'hFFFF;
   localparam logic [5:0]  MAX_EVENTS = 6'd32;

   // Append one decimal digit, saturating at the largest 16-bit value.
   function automatic logic [15:0] dec_push(input logic [15:0] v, input logic [3:0] d);
      logic [19:0] t;
      t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
      return (t > {4'd0, DEC_MAX}) ? DEC_MAX : t[15:0];
   endfunction

   // Letter finals: bit 5 says the letter names a key.
   function automatic logic [5:0] letter_key(input logic [7:0] f);
      logic [5:0] r;
      r = {1'b0, KC_ESC};
      unique case (f)
         8'h41:   r = {1'b1, KC_UP};
         8'h42:   r = {1'b1, KC_DOWN};
         8'h43:   r = {1'b1, KC_RIGHT};
         8'h44:   r = {1'b1, KC_LEFT};
         8'h48:   r = {1'b1, KC_HOME};
         8'h46:   r = {1'b1, KC_END};
         default: r = {1'b0, KC_ESC};
      endcase
      return r;
   endfunction

   // Numbered tilde keys.
   function automatic logic [4:0] tilde_key(input logic [15:0] num);
      logic [4:0] k;
      k = KC_ESC;
      unique case (num)
         16'd1, 16'd7: k = KC_HOME;
         16'd2:        k = KC_INS;
         16'd3:        k = KC_DEL;
         16'd4, 16'd8: k = KC_END;
         16'd5:        k = KC_PGUP;
         16'd6:        k = KC_PGDN;
         16'd11:       k = KC_F1;
         16'd12:       k = KC_F1 + 5'd1;
         16'd13:       k = KC_F1 + 5'd2;
         16'd14:       k = KC_F1 + 5'd3;
         16'd15:       k = KC_F1 + 5'd4;
         16'd17:       k = KC_F1 + 5'd5;
         16'd18:       k = KC_F1 + 5'd6;
         16'd19:       k = KC_F1 + 5'd7;
         16'd20:       k = KC_F1 + 5'd8;
         16'd21:       k = KC_F1 + 5'd9;
         16'd23:       k = KC_F1 + 5'd10;
         16'd24:       k = KC_F1 + 5'd11;
         default:      k = KC_ESC;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ktd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the pending byte buffer.
`default_nettype none

module ktd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/ktd_ctrl.sv
// Controller state machine: sequences store, scan, drop and result delivery.
// Depends on ktd_pkg for the command and status structs.
`default_nettype none

module ktd_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire ktd_pkg::sts_type sts,
   output ktd_pkg::cmd_type     cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_STORE     = 9'b000000010,
      S_START     = 9'b000000100,
      S_RD        = 9'b000001000,
      S_EV        = 9'b000010000,
      S_GOT       = 9'b000100000,
      S_CHK       = 9'b001000000,
      S_SEND_MID  = 9'b010000000,
      S_SEND_LAST = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   logic       held_ff, held_in;
   logic [5:0] evcnt_ff, evcnt_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND_MID) || (state_ff == S_SEND_LAST);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      evcnt_in = evcnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_STORE;
            end
         end
         S_STORE: begin
            if (!sts.is_eof) begin
               cmd.store = 1'b1;
            end
            state_in = S_START;
         end
         S_START: begin
            evcnt_in = '0;
            held_in  = 1'b0;
            if (sts.cnt_zero) begin
               state_in = S_IDLE;
            end else begin
               cmd.init = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (!sts.at_end) begin
               state_in = S_EV;
            end else if (sts.is_eof) begin
               cmd.resolve = 1'b1;
               state_in    = S_GOT;
            end else if (held_ff) begin
               cmd.ld_last = 1'b1;
               held_in     = 1'b0;
               state_in    = S_SEND_LAST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EV: begin
            cmd.step = 1'b1;
            state_in = sts.step_done ? S_GOT : S_RD;
         end
         S_GOT: begin
            cmd.drop = 1'b1;
            evcnt_in = evcnt_ff + 6'd1;
            if (held_ff) begin
               cmd.push = 1'b1;
               state_in = S_SEND_MID;
            end else begin
               cmd.hold = 1'b1;
               held_in  = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (sts.cnt_zero || (evcnt_ff == ktd_pkg::MAX_EVENTS)) begin
               cmd.ld_last = 1'b1;
               held_in     = 1'b0;
               state_in    = S_SEND_LAST;
            end else begin
               cmd.init = 1'b1;
               state_in = S_RD;
            end
         end
         S_SEND_MID: begin
            if (rsp_ready) begin
               state_in = S_CHK;
            end
         end
         S_SEND_LAST: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= 1'b0;
         evcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         evcnt_ff <= evcnt_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ktd_datapath.sv
// Datapath: pending byte ring, byte-serial front parser and event registers.
// Depends on ktd_pkg and ktd_ram.
`default_nettype none

module ktd_datapath #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ktd_pkg::req_type req_data,
   input  wire ktd_pkg::cmd_type cmd,
   output ktd_pkg::sts_type      sts,
   output ktd_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam logic [SW-1:0] DEPTH_S = SW'(BUF_DEPTH);

   typedef enum logic [7:0] {
      P_FIRST = 8'b00000001,
      P_ESC1  = 8'b00000010,
      P_ESC2  = 8'b00000100,
      P_X10   = 8'b00001000,
      P_SGR   = 8'b00010000,
      P_NUM   = 8'b00100000,
      P_MOD   = 8'b01000000,
      P_UTF   = 8'b10000000
   } mode_type;

   logic                  eof_ff;
   logic [7:0]            byte_ff;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   mode_type              mode_ff, mode_in;
   logic                  brk_ff, brk_in;
   logic [15:0]           num_ff, num_in;
   logic [15:0]           mx_ff, mx_in;
   logic [15:0]           my_ff, my_in;
   logic [1:0]            fld_ff, fld_in;
   logic [2:0]            len_ff, len_in;
   logic                  bad_ff, bad_in;
   logic [20:0]           cp_ff, cp_in;
   ktd_pkg::rsp_type      pe_ff, pe_in;
   logic [CW-1:0]         used_ff, used_in;
   ktd_pkg::rsp_type      held_ff;
   ktd_pkg::rsp_type      out_ff;
   logic                  done;

   logic [SW-1:0]         wsum, rsum, dsum;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [7:0]            c;
   logic [CW-1:0]         idx_p1;
   logic [5:0]            lk;
   logic                  is_dig, is_upper;
   logic [3:0]            dig;
   logic [20:0]           cp_acc;
   logic [20:0]           cp_min;

   // Ring addressing with one compare-and-subtract wrap.
   always_comb begin
      wsum = SW'(head_ff) + ((cnt_ff == CW'(BUF_DEPTH)) ? '0 : SW'(cnt_ff));
      rsum = SW'(head_ff) + SW'(idx_ff);
      dsum = SW'(head_ff) + SW'(used_ff);
      wr_addr = (wsum >= DEPTH_S) ? AW'(wsum - DEPTH_S) : AW'(wsum);
      rd_addr = (rsum >= DEPTH_S) ? AW'(rsum - DEPTH_S) : AW'(rsum);
   end

   ktd_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_buf (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(wr_addr),
      .wr_data(byte_ff),
      .rd_addr(rd_addr),
      .rd_data(c)
   );

   assign sts.is_eof   = eof_ff;
   assign sts.cnt_zero = (cnt_ff == '0);
   assign sts.at_end   = (idx_ff == cnt_ff);
   assign sts.step_done = done;
   assign rsp_data     = out_ff;

   // Classification of the current byte.
   always_comb begin
      idx_p1   = idx_ff + CW'(1);
      lk       = ktd_pkg::letter_key(c);
      is_dig   = (c >= 8'h30) && (c <= 8'h39);
      dig      = c[3:0];
      is_upper = (c >= 8'h41) && (c <= 8'h5A);
      cp_acc   = {cp_ff[14:0], c[5:0]};
      unique case (len_ff)
         3'd2:    cp_min = 21'h000080;
         3'd3:    cp_min = 21'h000800;
         default: cp_min = 21'h010000;
      endcase
   end

   // The current byte ends the form; decided from the mode, the byte and the scan index, bracket flag and UTF-8 length.
   always_comb begin
      done = 1'b0;
      unique case (mode_ff)
         P_FIRST: done = (c != ktd_pkg::CH_ESC) &&
                         !((c[7:5] == 3'b110) || (c[7:4] == 4'b1110) ||
                           (c[7:3] == 5'b11110));
         P_ESC1:  done = !((c == 8'h5B) || (c == 8'h4F));
         P_ESC2:  done = !((brk_ff && ((c == 8'h4D) || (c == 8'h3C))) || is_dig);
         P_X10:   done = (idx_ff != CW'(3)) && (idx_ff != CW'(4));
         P_SGR:   done = (c == 8'h4D) || (c == 8'h6D);
         P_NUM:   done = !is_dig && (c != 8'h3B);
         P_MOD:   done = (c == 8'h7E) || is_upper;
         P_UTF:   done = (idx_ff == CW'(len_ff - 3'd1));
         default: done = 1'b0;
      endcase
   end

   // Scan restart, one parser step on the byte at the scan index, or the end-of-input resolution.
   always_comb begin
      mode_in = mode_ff;
      idx_in  = idx_ff;
      brk_in  = brk_ff;
      num_in  = num_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      fld_in  = fld_ff;
      len_in  = len_ff;
      bad_in  = bad_ff;
      cp_in   = cp_ff;
      pe_in   = pe_ff;
      used_in = used_ff;
      if (cmd.init) begin
         mode_in = P_FIRST;
         idx_in  = '0;
      end else if (cmd.resolve) begin
         // Input ended inside a form: one byte goes, as ESC or a bad character.
         pe_in   = '0;
         used_in = CW'(1);
         if (mode_ff == P_UTF) begin
            pe_in.key_code   = ktd_pkg::KC_CHAR;
            pe_in.code_point = ktd_pkg::CP_BAD;
         end else begin
            pe_in.key_code = ktd_pkg::KC_ESC;
         end
      end else if (cmd.step) begin
         idx_in = idx_p1;
         unique case (mode_ff)
            P_FIRST: begin
               pe_in   = '0;
               used_in = CW'(1);
               priority if (c == ktd_pkg::CH_ESC) begin
                  mode_in = P_ESC1;
               end else if ((c == 8'h0D) || (c == 8'h0A)) begin
                  pe_in.key_code = ktd_pkg::KC_ENTER;
               end else if (c == 8'h09) begin
                  pe_in.key_code = ktd_pkg::KC_TAB;
               end else if ((c == 8'h7F) || (c == 8'h08)) begin
                  pe_in.key_code = ktd_pkg::KC_BKSP;
               end else if (c < 8'h20) begin
                  pe_in.key_code = ktd_pkg::KC_CTRL;
                  if (c == 8'h00) begin
                     pe_in.code_point = 21'd32;
                  end else if (c < 8'd27) begin
                     pe_in.code_point = {13'd0, 8'h60 + c};
                  end else begin
                     pe_in.code_point = {13'd0, 8'h40 + c};
                  end
               end else begin
                  pe_in.key_code = ktd_pkg::KC_CHAR;
                  bad_in = 1'b0;
                  priority if (c[7:5] == 3'b110) begin
                     mode_in = P_UTF; len_in = 3'd2;
                     cp_in = {16'd0, c[4:0]};
                  end else if (c[7:4] == 4'b1110) begin
                     mode_in = P_UTF; len_in = 3'd3;
                     cp_in = {17'd0, c[3:0]};
                  end else if (c[7:3] == 5'b11110) begin
                     mode_in = P_UTF; len_in = 3'd4;
                     cp_in = {18'd0, c[2:0]};
                  end else begin
                     pe_in.code_point = {13'd0, c};
                  end
               end
            end
            P_ESC1: begin
               if ((c == 8'h5B) || (c == 8'h4F)) begin
                  brk_in  = (c == 8'h5B);
                  mode_in = P_ESC2;
               end else begin
                  pe_in   = '0;
                  used_in = CW'(1);
               end
            end
            P_ESC2: begin
               num_in = '0;
               mx_in  = '0;
               my_in  = '0;
               fld_in = '0;
               priority if ((c >= 8'h50) && (c <= 8'h53)) begin
                  pe_in = '0;
                  pe_in.key_code = ktd_pkg::KC_F1 + {3'd0, c[1:0]};
                  used_in = CW'(3);
               end else if (lk[5]) begin
                  pe_in = '0;
                  pe_in.key_code = lk[4:0];
                  used_in = CW'(3);
               end else if (brk_ff && (c == 8'h4D)) begin
                  pe_in = '0;
                  pe_in.event_kind = 1'b1;
                  mode_in = P_X10;
               end else if (brk_ff && (c == 8'h3C)) begin
                  mode_in = P_SGR;
               end else if (is_dig) begin
                  num_in  = {12'd0, dig};
                  mode_in = P_NUM;
               end else begin
                  pe_in   = '0;
                  used_in = CW'(1);
               end
            end
            P_X10: begin
               // Button, column and row bytes; column and row are offset by 33, the button keeps its low two bits.
               if (idx_ff == CW'(3)) begin
                  pe_in.mouse_button = c[1:0];
               end else if (idx_ff == CW'(4)) begin
                  pe_in.mouse_col = (c >= 8'd33) ? {8'd0, c - 8'd33} : 16'd0;
               end else begin
                  pe_in.mouse_row = (c >= 8'd33) ? {8'd0, c - 8'd33} : 16'd0;
                  used_in = idx_p1;
               end
            end
            P_SGR: begin
               if ((c == 8'h4D) || (c == 8'h6D)) begin
                  pe_in = '0;
                  pe_in.event_kind   = 1'b1;
                  pe_in.mouse_button = num_ff[1:0];
                  pe_in.mouse_col    = (mx_ff != '0) ? mx_ff - 16'd1 : 16'd0;
                  pe_in.mouse_row    = (my_ff != '0) ? my_ff - 16'd1 : 16'd0;
                  used_in = idx_p1;
               end else if (c == 8'h3B) begin
                  if (fld_ff != 2'd2) begin
                     fld_in = fld_ff + 2'd1;
                  end
               end else if (is_dig) begin
                  unique case (fld_ff)
                     2'd0:    num_in = ktd_pkg::dec_push(num_ff, dig);
                     2'd1:    mx_in  = ktd_pkg::dec_push(mx_ff, dig);
                     default: my_in  = ktd_pkg::dec_push(my_ff, dig);
                  endcase
               end
            end
            P_NUM, P_MOD: begin
               if ((mode_ff == P_NUM) && is_dig) begin
                  num_in = ktd_pkg::dec_push(num_ff, dig);
               end else if ((mode_ff == P_NUM) && (c == 8'h3B)) begin
                  mode_in = P_MOD;
               end else if (c == 8'h7E) begin
                  pe_in = '0;
                  pe_in.key_code = ktd_pkg::tilde_key(num_ff);
                  used_in = idx_p1;
               end else if (is_upper) begin
                  pe_in = '0;
                  pe_in.key_code = lk[5] ? lk[4:0] : ktd_pkg::KC_ESC;
                  used_in = idx_p1;
               end else if (mode_ff == P_NUM) begin
                  pe_in   = '0;
                  used_in = CW'(1);
               end
            end
            P_UTF: begin
               bad_in = bad_ff | (c[7:6] != 2'b10);
               cp_in  = cp_acc;
               if (idx_ff == CW'(len_ff - 3'd1)) begin
                  pe_in = '0;
                  pe_in.key_code = ktd_pkg::KC_CHAR;
                  pe_in.code_point = (bad_in || (cp_acc < cp_min) ||
                                      (cp_acc > ktd_pkg::CP_MAX)) ? ktd_pkg::CP_BAD
                                                                  : cp_acc;
                  used_in = idx_p1;
               end
            end
            default: mode_in = P_FIRST;
         endcase
      end
   end

   // Ring head and fill count.
   always_comb begin
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (cmd.store) begin
         cnt_in = (cnt_ff == CW'(BUF_DEPTH)) ? CW'(1) : cnt_ff + CW'(1);
      end else if (cmd.drop) begin
         head_in = (dsum >= DEPTH_S) ? AW'(dsum - DEPTH_S) : AW'(dsum);
         cnt_in  = cnt_ff - used_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
         mode_ff <= P_FIRST;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
         mode_ff <= mode_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         eof_ff  <= (req_data.func == ktd_pkg::FUNC_FLUSH);
         byte_ff <= req_data.in_byte;
      end
      idx_ff  <= idx_in;
      brk_ff  <= brk_in;
      num_ff  <= num_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      fld_ff  <= fld_in;
      len_ff  <= len_in;
      bad_ff  <= bad_in;
      cp_ff   <= cp_in;
      pe_ff   <= pe_in;
      used_ff <= used_in;
      if (cmd.push || cmd.hold) begin
         held_ff <= pe_ff;
      end
      // The last-event flag is the lowest bit of the result item.
      if (cmd.push) begin
         out_ff <= {held_ff[$bits(ktd_pkg::rsp_type)-1:1], 1'b0};
      end else if (cmd.ld_last) begin
         out_ff <= {held_ff[$bits(ktd_pkg::rsp_type)-1:1], 1'b1};
      end
   end

endmodule

`default_nettype wire

### hw/rtl/terminal_key_escape_decoder.sv
// Terminal key escape decoder: an item is accepted only while idle. A byte passes a
// store and a start state; each event then rescans the pending bytes from the front,
// with a RAM read and a parser step per byte, followed by drop, check and delivery;
// a result stall holds the block in delivery. Synchronous reset empties the pending
// buffer and returns to idle.
`default_nettype none

module terminal_key_escape_decoder #(
   parameter int BUF_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ktd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ktd_pkg::rsp_type      rsp_data
);

   ktd_pkg::cmd_type cmd;
   ktd_pkg::sts_type sts;

   ktd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ktd_datapath #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

### dv/tb_terminal_key_escape_decoder.sv
// Testbench for the terminal key escape decoder: drives bytes and flush items,
// predicts key and mouse events and checks every result item.
// Depends on ktd_pkg and the terminal_key_escape_decoder RTL.
`timescale 1ns / 1ps

module tb_terminal_key_escape_decoder;

   localparam int DEPTH      = 32;
   localparam int STALL_MAX  = 20000;
   localparam int TAIL_WAIT  = 600;

   // Keeps the events still owed by the block and compares arriving ones.
   class event_scoreboard;
      ktd_pkg::rsp_type owed[$];
      int               errors;

      function void note_item(ktd_pkg::rsp_type evs[$]);
         foreach (evs[i]) owed.push_back(evs[i]);
      endfunction

      task check_event(ktd_pkg::rsp_type got);
         ktd_pkg::rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch("event with nothing owed", '0, got);
            return;
         end
         want = owed.pop_front();
         if (got.event_kind !== want.event_kind) report_mismatch("event_kind", want, got);
         if (got.key_code !== want.key_code) report_mismatch("key_code", want, got);
         if (got.code_point !== want.code_point) report_mismatch("code_point", want, got);
         if (got.mouse_button !== want.mouse_button)
            report_mismatch("mouse_button", want, got);
         if (got.mouse_col !== want.mouse_col) report_mismatch("mouse_col", want, got);
         if (got.mouse_row !== want.mouse_row) report_mismatch("mouse_row", want, got);
         if (got.last_event !== want.last_event) report_mismatch("last_event", want, got);
      endtask

      task report_mismatch(string what, ktd_pkg::rsp_type want, ktd_pkg::rsp_type got);
         errors++;
         $display("MISMATCH %s at %0t: want %h got %h", what, $time, want, got);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ktd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ktd_pkg::rsp_type rsp_data;

   event_scoreboard board = new();

   // Predictor copy of the pending byte buffer.
   logic [7:0] held[DEPTH];
   int         held_n;

   int send_idle_pct, recv_idle_pct;
   int stall_cycles;

   terminal_key_escape_decoder #(.BUF_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] add_digit(logic [15:0] v, int d);
      int t;
      t = v * 10 + d;
      return (t > 65535) ? 16'hFFFF : t[15:0];
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit arrow_letter(logic [7:0] f, output logic [4:0] k);
      k = ktd_pkg::KC_ESC;
      case (f)
         "A": k = ktd_pkg::KC_UP;
         "B": k = ktd_pkg::KC_DOWN;
         "C": k = ktd_pkg::KC_RIGHT;
         "D": k = ktd_pkg::KC_LEFT;
         "H": k = ktd_pkg::KC_HOME;
         "F": k = ktd_pkg::KC_END;
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic [4:0] numbered_key(logic [15:0] num);
      case (num)
         1, 7: return ktd_pkg::KC_HOME;
         2: return ktd_pkg::KC_INS;
         3: return ktd_pkg::KC_DEL;
         4, 8: return ktd_pkg::KC_END;
         5: return ktd_pkg::KC_PGUP;
         6: return ktd_pkg::KC_PGDN;
         11, 12, 13, 14, 15: return ktd_pkg::KC_F1 + 5'(num - 11);
         17, 18, 19, 20, 21: return ktd_pkg::KC_F1 + 5'(num - 12);
         23, 24: return ktd_pkg::KC_F1 + 5'(num - 13);
         default: return ktd_pkg::KC_ESC;
      endcase
   endfunction

   function automatic logic [20:0] utf8_value(int len);
      logic [31:0] v;
      for (int i = 1; i < len; i++)
         if (held[i][7:6] != 2'b10) return ktd_pkg::CP_BAD;
      case (len)
         2: begin
            v = {held[0][4:0], held[1][5:0]};
            return (v < 32'h80) ? ktd_pkg::CP_BAD : v[20:0];
         end
         3: begin
            v = {held[0][3:0], held[1][5:0], held[2][5:0]};
            return (v < 32'h800) ? ktd_pkg::CP_BAD : v[20:0];
         end
         4: begin
            v = {held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
            return (v < 32'h10000 || v > 32'h10FFFF) ? ktd_pkg::CP_BAD : v[20:0];
         end
         default: return {13'd0, held[0]};
      endcase
   endfunction

   // Decodes one event from the front of the buffer; returns bytes used, 0 to wait.
   function automatic int decode_front(bit flush, output ktd_pkg::rsp_type e);
      logic [7:0]  c, t, f, fin;
      logic [15:0] num, bt, mx, my;
      int          n, i, j, stop, fld, len;
      e = '0;
      n = held_n;
      c = held[0];
      e.key_code = ktd_pkg::KC_ESC;
      if (c == ktd_pkg::CH_ESC) begin
         if (n == 1) return flush ? 1 : 0;
         t = held[1];
         if (t != "[" && t != "O") return 1;
         if (n < 3) return flush ? 1 : 0;
         f = held[2];
         if (f >= "P" && f <= "S") begin
            e.key_code = ktd_pkg::KC_F1 + 5'(f - "P");
            return 3;
         end
         if (arrow_letter(f, e.key_code)) return 3;
         if (t == "[" && f == "M") begin
            if (n < 6) return flush ? 1 : 0;
            e.event_kind = 1'b1;
            e.key_code = ktd_pkg::KC_ESC;
            e.mouse_button = held[3][1:0];
            e.mouse_col = (held[4] >= 33) ? 16'(held[4] - 33) : 16'd0;
            e.mouse_row = (held[5] >= 33) ? 16'(held[5] - 33) : 16'd0;
            return 6;
         end
         if (t == "[" && f == "<") begin
            stop = n;
            for (i = 3; i < n; i++)
               if (held[i] == "M" || held[i] == "m") begin
                  stop = i;
                  break;
               end
            if (stop == n) return flush ? 1 : 0;
            bt = 0; mx = 0; my = 0; fld = 0;
            for (i = 3; i < stop; i++) begin
               if (held[i] == ";") begin
                  if (fld < 2) fld++;
               end else if (is_digit(held[i])) begin
                  if (fld == 0) bt = add_digit(bt, held[i] - "0");
                  else if (fld == 1) mx = add_digit(mx, held[i] - "0");
                  else my = add_digit(my, held[i] - "0");
               end
            end
            e.event_kind = 1'b1;
            e.key_code = ktd_pkg::KC_ESC;
            e.mouse_button = bt[1:0];
            e.mouse_col = (mx > 0) ? mx - 16'd1 : 16'd0;
            e.mouse_row = (my > 0) ? my - 16'd1 : 16'd0;
            return stop + 1;
         end
         if (is_digit(f)) begin
            i = 2;
            num = 0;
            while (i < n && is_digit(held[i])) begin
               num = add_digit(num, held[i] - "0");
               i++;
            end
            if (i >= n) return flush ? 1 : 0;
            fin = held[i];
            if (fin == ";") begin
               j = i + 1;
               while (j < n && !((held[j] >= "A" && held[j] <= "Z") || held[j] == "~")) j++;
               if (j >= n) return flush ? 1 : 0;
               fin = held[j];
               i = j;
            end
            if (fin == "~") begin
               e.key_code = numbered_key(num);
               return i + 1;
            end
            if (fin >= "A" && fin <= "Z") begin
               if (!arrow_letter(fin, e.key_code)) e.key_code = ktd_pkg::KC_ESC;
               return i + 1;
            end
         end
         return 1;
      end
      if (c == 8'h0D || c == 8'h0A) begin
         e.key_code = ktd_pkg::KC_ENTER;
         return 1;
      end
      if (c == 8'h09) begin
         e.key_code = ktd_pkg::KC_TAB;
         return 1;
      end
      if (c == 8'h7F || c == 8'h08) begin
         e.key_code = ktd_pkg::KC_BKSP;
         return 1;
      end
      if (c < 8'h20) begin
         e.key_code = ktd_pkg::KC_CTRL;
         if (c == 0) e.code_point = " ";
         else if (c < 27) e.code_point = 21'("a" + c - 1);
         else e.code_point = "@" + c;
         return 1;
      end
      if (c < 8'h80) len = 1;
      else if (c[7:5] == 3'b110) len = 2;
      else if (c[7:4] == 4'b1110) len = 3;
      else if (c[7:3] == 5'b11110) len = 4;
      else len = 1;
      e.key_code = ktd_pkg::KC_CHAR;
      if (len > n) begin
         if (!flush) return 0;
         e.code_point = ktd_pkg::CP_BAD;
         return 1;
      end
      e.code_point = utf8_value(len);
      return len;
   endfunction

   // Works out all events caused by one accepted item and updates the buffer.
   function automatic void predict_events(ktd_pkg::req_type r);
      ktd_pkg::rsp_type evs[$];
      ktd_pkg::rsp_type e;
      int               used;
      if (r.func == ktd_pkg::FUNC_BYTE) begin
         if (held_n >= DEPTH) held_n = 0;
         held[held_n] = r.in_byte;
         held_n++;
      end
      while (evs.size() < 32 && held_n > 0) begin
         used = decode_front(r.func == ktd_pkg::FUNC_FLUSH, e);
         if (used == 0) break;
         if (used >= held_n) held_n = 0;
         else begin
            for (int i = 0; i < held_n - used; i++) held[i] = held[i + used];
            held_n -= used;
         end
         evs.push_back(e);
      end
      if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
      board.note_item(evs);
   endfunction

   // Result side: random stalls, checking every accepted event.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_event(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Sends one item and waits for its acceptance; valid stays up for a following item.
   task automatic send_item(logic f, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{func: f, in_byte: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_events('{func: f, in_byte: b});
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(ktd_pkg::FUNC_BYTE, s[i]);
   endtask

   task automatic send_num(int v);
      send_text($sformatf("%0d", v));
   endtask

   // One random well-formed or broken sequence.
   task automatic send_random_sequence();
      string finals = "ABCDHFPQRS";
      int    k;
      k = $urandom_range(13);
      case (k)
         0: send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(255)));
         1: send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(31)));
         2: begin
            send_item(ktd_pkg::FUNC_BYTE, ktd_pkg::CH_ESC);
            send_item(ktd_pkg::FUNC_BYTE, $urandom_range(1) ? 8'h5B : 8'h4F);
            send_item(ktd_pkg::FUNC_BYTE, finals[$urandom_range(9)]);
         end
         3: begin
            send_text("\033[");
            send_num($urandom_range(25));
            send_item(ktd_pkg::FUNC_BYTE, "~");
         end
         4: begin
            send_text("\033[");
            send_num($urandom_range(25));
            send_text(";");
            send_num($urandom_range(8));
            send_item(ktd_pkg::FUNC_BYTE,
                      $urandom_range(1) ? 8'h7E : 8'($urandom_range(8'h41, 8'h5A)));
         end
         5: begin
            send_text("\033[M");
            repeat (3) send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(255)));
         end
         6: begin
            send_text("\033[<");
            send_num($urandom_range(1) ? $urandom_range(99) : $urandom_range(99999));
            send_text(";");
            send_num($urandom_range(300));
            send_text(";");
            send_num($urandom_range(300));
            send_item(ktd_pkg::FUNC_BYTE, $urandom_range(1) ? 8'h4D : 8'h6D);
         end
         7: begin
            send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'hC2, 8'hDF)));
            send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'h80, 8'hBF)));
         end
         8: begin
            send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'h80, 8'hBF)));
         end
         9: begin
            send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'h80, 8'hBF)));
         end
         10: send_item(ktd_pkg::FUNC_FLUSH, 8'($urandom_range(255)));
         11: begin
            send_item(ktd_pkg::FUNC_BYTE, ktd_pkg::CH_ESC);
            send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(255)));
         end
         12: send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
         default: begin
            send_text("\033[");
            repeat ($urandom_range(4))
               send_item(ktd_pkg::FUNC_BYTE, 8'($urandom_range(255)));
         end
      endcase
   endtask

   initial begin
      held_n = 0;
      send_idle_pct = 7;
      recv_idle_pct = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: keys, mouse forms, bad UTF-8, truncation and a full buffer.
      send_text("\033[A\033OQ\033[5~\033[1;5C\033[99~\033[1;5Z\033[x");
      send_item(ktd_pkg::FUNC_BYTE, 8'h00);
      send_item(ktd_pkg::FUNC_BYTE, 8'h1C);
      send_text("\r\t");
      send_item(ktd_pkg::FUNC_BYTE, 8'h7F);
      send_text("\033[M\040\041\377\033[<99999;0;70000m");
      send_item(ktd_pkg::FUNC_BYTE, 8'hC0);
      send_item(ktd_pkg::FUNC_BYTE, 8'h80);
      send_item(ktd_pkg::FUNC_BYTE, 8'hF4);
      send_item(ktd_pkg::FUNC_BYTE, 8'h90);
      send_item(ktd_pkg::FUNC_BYTE, 8'h80);
      send_item(ktd_pkg::FUNC_BYTE, 8'h80);
      send_item(ktd_pkg::FUNC_BYTE, 8'hFF);
      send_item(ktd_pkg::FUNC_BYTE, 8'hE2);
      send_item(ktd_pkg::FUNC_FLUSH, 8'hFF);
      send_text("\033[12;");
      send_item(ktd_pkg::FUNC_FLUSH, 8'h00);
      send_item(ktd_pkg::FUNC_FLUSH, 8'h00);
      send_text("\033[<");
      repeat (34) send_item(ktd_pkg::FUNC_BYTE, "1");
      send_item(ktd_pkg::FUNC_FLUSH, 8'h00);

      // Random part in three idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 88 : 0;
         recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 7 : 0;
         repeat (8) send_random_sequence();
         if ($urandom_range(1)) send_item(ktd_pkg::FUNC_FLUSH, 8'h00);
      end
      req_valid <= 1'b0;

      while (board.owed.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (board.errors == 0 && board.owed.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

### files.f
hw/rtl/ktd_pkg.sv
hw/rtl/ktd_ram.sv
hw/rtl/ktd_ctrl.sv
hw/rtl/ktd_datapath.sv
hw/rtl/terminal_key_escape_decoder.sv
dv/tb_terminal_key_escape_decoder.sv
